[src/complex_arithmetic_unit_assert.svh]
// Assertion macros shared by the checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Property checked outside reset.
`define CAU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property that must also hold across reset.
`define CAU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[src/cau_pkg.sv]
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int PW = 2 * DW;
  localparam int MW = 2 * DW + 1;
  localparam int CW = MW + DW;
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]           func;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } op_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 saturated;
    logic                 div_zero;
  } res_t;

  // Classified item passed from front to back.
  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic          re_neg;
    logic [MW-1:0] re_mag;
    logic          im_neg;
    logic [MW-1:0] im_mag;
    logic [MW-1:0] den;
  } work_t;

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] mag;
    logic          ovf;
    logic [CW-1:0] rem;
    logic [DW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic [MW-1:0] den;
    lane_t         re;
    lane_t         im;
  } bst_t;

  localparam logic [MW-1:0] POS_LIM = (MW'(1) << (DW - 1)) - MW'(1);
  localparam logic [MW-1:0] NEG_LIM = MW'(1) << (DW - 1);

  // Returns {sat, value}.
  function automatic logic [DW:0] clip(input logic neg, input logic [MW-1:0] mag);
    logic [DW-1:0] v;
    logic          s;
    s = 1'b0;
    if (neg) begin
      if (mag > NEG_LIM) begin
        s = 1'b1;
        v = NEG_LIM[DW-1:0];
      end else begin
        v = DW'(0) - mag[DW-1:0];
      end
    end else begin
      if (mag > POS_LIM) begin
        s = 1'b1;
        v = POS_LIM[DW-1:0];
      end else begin
        v = mag[DW-1:0];
      end
    end
    return {s, v};
  endfunction

endpackage

[src/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Channel  Valid      Stall      Payload
// op       op_valid   op_stall   op  (func, a_re, a_im, b_re, b_im)
// res      res_valid  res_stall  res (res_re, res_im, saturated, div_zero)
//
// One operation per cycle sustained while op_stall and res_stall are low; after the op
// transfer the item passes two front stages, the queue and the 16-step restoring
// divide pipeline plus output register that every item passes through.
// Synchronous reset empties the front stages, the queue and the divider.
// res_stall holds the back end only; the front keeps filling the queue
// until it is full, then raises op_stall.
module complex_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_stall,
  input  cau_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_stall,
  output cau_pkg::res_t res
);

  logic           full;
  logic           push;
  logic           pop;
  logic           nonempty;
  cau_pkg::work_t wdata;
  cau_pkg::work_t rdata;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .op       (op),
    .full     (full),
    .push     (push),
    .work     (wdata)
  );

  cau_fifo #(
    .DEPTH (cau_pkg::QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wdata),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .rdata    (rdata)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .work      (rdata),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[src/cau_front.sv]
`timescale 1ns / 1ps
module cau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_stall,
  input  cau_pkg::op_t  op,
  input  logic          full,
  output logic          push,
  output cau_pkg::work_t work
);

  typedef logic signed [cau_pkg::PW-1:0] prod_t;
  typedef logic signed [cau_pkg::MW-1:0] wide_t;
  typedef logic signed [cau_pkg::DW:0]   sum_t;

  logic          en;
  logic          v1;
  logic          v2;
  cau_pkg::op_t  s1;
  logic [1:0]    func2;
  prod_t         p_rr;
  prod_t         p_ii;
  prod_t         p_ri;
  prod_t         p_ir;
  prod_t         sq_r;
  prod_t         sq_i;
  sum_t          s_re;
  sum_t          s_im;
  wide_t         x_re;
  wide_t         x_im;
  wide_t         den_s;
  logic [cau_pkg::MW-1:0] m_re;
  logic [cau_pkg::MW-1:0] m_im;

  assign en       = !full;
  assign op_stall = full;
  assign push     = v2 && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= op_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= op;
      func2 <= s1.func;
      p_rr  <= prod_t'(s1.a_re) * prod_t'(s1.b_re);
      p_ii  <= prod_t'(s1.a_im) * prod_t'(s1.b_im);
      p_ri  <= prod_t'(s1.a_re) * prod_t'(s1.b_im);
      p_ir  <= prod_t'(s1.a_im) * prod_t'(s1.b_re);
      sq_r  <= prod_t'(s1.b_re) * prod_t'(s1.b_re);
      sq_i  <= prod_t'(s1.b_im) * prod_t'(s1.b_im);
      if (s1.func == cau_pkg::FUNC_ADD) begin
        s_re <= sum_t'(s1.a_re) + sum_t'(s1.b_re);
        s_im <= sum_t'(s1.a_im) + sum_t'(s1.b_im);
      end else begin
        s_re <= sum_t'(s1.a_re) - sum_t'(s1.b_re);
        s_im <= sum_t'(s1.a_im) - sum_t'(s1.b_im);
      end
    end
  end

  always_comb begin
    den_s = wide_t'(sq_r) + wide_t'(sq_i);
    case (func2)
      cau_pkg::FUNC_MUL: begin
        x_re = wide_t'(p_rr) - wide_t'(p_ii);
        x_im = wide_t'(p_ri) + wide_t'(p_ir);
      end
      cau_pkg::FUNC_DIV: begin
        x_re = wide_t'(p_rr) + wide_t'(p_ii);
        x_im = wide_t'(p_ir) - wide_t'(p_ri);
      end
      default: begin
        x_re = wide_t'(s_re);
        x_im = wide_t'(s_im);
      end
    endcase
    m_re = x_re[cau_pkg::MW-1] ? cau_pkg::MW'(0) - x_re : x_re;
    m_im = x_im[cau_pkg::MW-1] ? cau_pkg::MW'(0) - x_im : x_im;

    work.is_div = 1'b0;
    work.dz     = 1'b0;
    work.re_neg = x_re[cau_pkg::MW-1];
    work.im_neg = x_im[cau_pkg::MW-1];
    work.re_mag = m_re;
    work.im_mag = m_im;
    work.den    = den_s;
    case (func2)
      cau_pkg::FUNC_MUL: begin
        work.re_mag = m_re >> cau_pkg::FB;
        work.im_mag = m_im >> cau_pkg::FB;
      end
      cau_pkg::FUNC_DIV: begin
        if (den_s == '0) begin
          work.dz     = 1'b1;
          work.re_neg = 1'b0;
          work.im_neg = 1'b0;
          work.re_mag = '0;
          work.im_mag = '0;
        end else begin
          work.is_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/cau_fifo.sv]
`timescale 1ns / 1ps
module cau_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cau_pkg::work_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output cau_pkg::work_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cau_pkg::work_t    mem [DEPTH];
  logic [AW-1:0]     wp;
  logic [AW-1:0]     rp;
  logic [AW:0]       cnt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt == (AW + 1)'(DEPTH));
  assign nonempty = (cnt != '0);
  assign rdata    = mem[rp];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      cnt <= cnt + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

[src/cau_back.sv]
`timescale 1ns / 1ps
module cau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           nonempty,
  input  cau_pkg::work_t work,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output cau_pkg::res_t  res
);

  localparam int NS = cau_pkg::DW + 1;

  cau_pkg::bst_t st [NS];
  logic          vld [NS];
  logic          en;
  cau_pkg::bst_t init;
  logic [cau_pkg::DW:0] c_re;
  logic [cau_pkg::DW:0] c_im;
  logic [cau_pkg::MW-1:0] f_re;
  logic [cau_pkg::MW-1:0] f_im;

  function automatic cau_pkg::lane_t lane_init(input logic neg,
                                               input logic [cau_pkg::MW-1:0] mag,
                                               input logic [cau_pkg::MW-1:0] den);
    cau_pkg::lane_t l;
    logic [cau_pkg::CW-1:0] n;
    logic [cau_pkg::CW-1:0] d;
    n     = cau_pkg::CW'(mag) << cau_pkg::FB;
    d     = cau_pkg::CW'(den) << cau_pkg::DW;
    l.neg = neg;
    l.mag = mag;
    l.ovf = (n >= d);
    l.rem = n;
    l.q   = '0;
    return l;
  endfunction

  function automatic cau_pkg::lane_t lane_step(input cau_pkg::lane_t l,
                                               input logic [cau_pkg::MW-1:0] den,
                                               input int sh);
    cau_pkg::lane_t r;
    logic [cau_pkg::CW:0] t;
    r = l;
    t = {1'b0, l.rem} - ((cau_pkg::CW + 1)'(den) << sh);
    if (!t[cau_pkg::CW]) begin
      r.rem = t[cau_pkg::CW-1:0];
      r.q   = l.q | (cau_pkg::DW'(1) << sh);
    end
    return r;
  endfunction

  assign en  = !res_valid || !res_stall;
  assign pop = en && nonempty;

  always_comb begin
    init.is_div = work.is_div;
    init.dz     = work.dz;
    init.den    = work.den;
    init.re     = lane_init(work.re_neg, work.re_mag, work.den);
    init.im     = lane_init(work.im_neg, work.im_mag, work.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        vld[k] <= 1'b0;
      end
      res_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= nonempty;
      for (int k = 1; k < NS; k++) begin
        vld[k] <= vld[k-1];
      end
      res_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= init;
      for (int k = 1; k < NS; k++) begin
        st[k].is_div <= st[k-1].is_div;
        st[k].dz     <= st[k-1].dz;
        st[k].den    <= st[k-1].den;
        st[k].re     <= lane_step(st[k-1].re, st[k-1].den, cau_pkg::DW - k);
        st[k].im     <= lane_step(st[k-1].im, st[k-1].den, cau_pkg::DW - k);
      end
    end
  end

  always_comb begin
    f_re = st[NS-1].re.mag;
    f_im = st[NS-1].im.mag;
    if (st[NS-1].is_div) begin
      f_re = st[NS-1].re.ovf ? '1 : cau_pkg::MW'(st[NS-1].re.q);
      f_im = st[NS-1].im.ovf ? '1 : cau_pkg::MW'(st[NS-1].im.q);
    end
    c_re = cau_pkg::clip(st[NS-1].re.neg, f_re);
    c_im = cau_pkg::clip(st[NS-1].im.neg, f_im);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.res_re    <= c_re[cau_pkg::DW-1:0];
      res.res_im    <= c_im[cau_pkg::DW-1:0];
      res.saturated <= c_re[cau_pkg::DW] || c_im[cau_pkg::DW];
      res.div_zero  <= st[NS-1].dz;
    end
  end

endmodule

[src/cau_checker.sv]
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"
module cau_sva (
  input logic          clk,
  input logic          rst,
  input logic          op_valid,
  input logic          op_stall,
  input cau_pkg::op_t  op,
  input logic          res_valid,
  input logic          res_stall,
  input cau_pkg::res_t res
);

  localparam logic signed [cau_pkg::DW-1:0] MAXV = cau_pkg::POS_LIM[cau_pkg::DW-1:0];
  localparam logic signed [cau_pkg::DW-1:0] MINV = cau_pkg::NEG_LIM[cau_pkg::DW-1:0];

  logic re_lim;
  logic im_lim;
  logic dz_clean;

  assign re_lim   = (res.res_re == MAXV) || (res.res_re == MINV);
  assign im_lim   = (res.res_im == MAXV) || (res.res_im == MINV);
  assign dz_clean = (res.res_re == '0) && (res.res_im == '0) && !res.saturated;

  `CAU_ASSERT(a_op_hold, clk, rst, op_valid && op_stall |=> op_valid && $stable(op))
  `CAU_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res))
  `CAU_ASSERT(a_dz_zero, clk, rst, res_valid && res.div_zero |-> dz_clean)
  `CAU_ASSERT(a_sat_lim, clk, rst, res_valid && res.saturated |-> re_lim || im_lim)
  `CAU_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !res_valid)

endmodule

bind complex_arithmetic_unit cau_sva u_cau_sva (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (op_valid),
  .op_stall  (op_stall),
  .op        (op),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

[tb/cau_checker.sv]
`timescale 1ns / 1ps
module cau_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  logic          op_stall,
  input  cau_pkg::op_t  op,
  input  logic          res_valid,
  input  logic          res_stall,
  input  cau_pkg::res_t res,
  output int            fails,
  output int            pending
);
  import cau_pkg::*;

  res_t expected_q[$];

  function automatic logic [15:0] sat16(input logic signed [63:0] v, inout logic s);
    if (v > 64'sd32767) begin
      s = 1'b1;
      return 16'h7fff;
    end
    if (v < -64'sd32768) begin
      s = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // floor(|n| * 2^8 / d) with sign, quotient capped as in the spec
  function automatic logic signed [63:0] qdiv(input logic signed [63:0] n,
                                             input logic [63:0] d);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    m = n < 0 ? -n : n;
    q = m / d;
    r = m % d;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    q = (q << 8) + ((r << 8) / d);
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic res_t complex_result(input op_t o);
    res_t x;
    logic signed [63:0] ar, ai, br, bi, pr, pi;
    logic [63:0] den;
    logic s;
    ar = o.a_re; ai = o.a_im; br = o.b_re; bi = o.b_im;
    s = 1'b0;
    x = '0;
    case (func_t'(o.func))
      FUNC_ADD: begin
        x.res_re = sat16(ar + br, s);
        x.res_im = sat16(ai + bi, s);
      end
      FUNC_SUB: begin
        x.res_re = sat16(ar - br, s);
        x.res_im = sat16(ai - bi, s);
      end
      FUNC_MUL: begin
        pr = ar * br - ai * bi;
        pi = ar * bi + ai * br;
        // truncation toward zero of the magnitude
        pr = pr < 0 ? -((-pr) >>> 8) : pr >>> 8;
        pi = pi < 0 ? -((-pi) >>> 8) : pi >>> 8;
        x.res_re = sat16(pr, s);
        x.res_im = sat16(pi, s);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) x.div_zero = 1'b1;
        else begin
          x.res_re = sat16(qdiv(ar * br + ai * bi, den), s);
          x.res_im = sat16(qdiv(ai * br - ar * bi, den), s);
        end
      end
    endcase
    x.saturated = s;
    return x;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (op_valid && !op_stall) expected_q.push_back(complex_result(op));
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected result %h", res);
        end else begin
          e = expected_q.pop_front();
          if (e !== res) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("result: expected re %h im %h sat %b dz %b, got re %h im %h sat %b dz %b",
                       e.res_re, e.res_im, e.saturated, e.div_zero,
                       res.res_re, res.res_im, res.saturated, res.div_zero);
          end
        end
      end
    end
  end
endmodule

[tb/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  logic clk, rst;
  logic op_valid, op_stall, res_valid, res_stall;
  op_t  op;
  res_t res;
  int   fails, pending;
  bit   calm;
  op_t  directed[$];

  complex_arithmetic_unit u_top (.*);

  cau_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic op_t random_op();
    op_t o;
    o.func = 2'($urandom);
    o.a_re = pick_part();
    o.a_im = pick_part();
    o.b_re = pick_part();
    o.b_im = pick_part();
    if (o.func == FUNC_DIV && $urandom_range(0, 15) == 0) begin
      o.b_re = '0;
      o.b_im = '0;
    end
    return o;
  endfunction

  task automatic send(input op_t o);
    while (!calm && $urandom_range(0, 99) < 9) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid <= 1'b1;
    op <= o;
    @(posedge clk);
    while (op_stall) @(posedge clk);
  endtask

  always @(posedge clk)
    res_stall <= rst ? 1'b0 : (!calm && $urandom_range(0, 99) < 9);

  initial begin
    op_t o;
    int n;
    rst = 1'b1;
    op_valid = 1'b0;
    op = '0;
    res_stall = 1'b0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int f = 0; f < 4; f++) begin
      directed.push_back('{func: 2'(f), a_re: 16'h7fff, a_im: 16'h8000,
                           b_re: 16'h7fff, b_im: 16'h8000});
      directed.push_back('{func: 2'(f), a_re: 16'h8000, a_im: 16'h8000,
                           b_re: 16'h8000, b_im: 16'h8000});
      directed.push_back('{func: 2'(f), a_re: 16'h0100, a_im: 16'hff00,
                           b_re: 16'h0080, b_im: 16'h0000});
      directed.push_back('{func: 2'(f), a_re: 16'h0000, a_im: 16'h0000,
                           b_re: 16'h0001, b_im: 16'hffff});
    end
    directed.push_back('{func: FUNC_DIV, a_re: 16'h1234, a_im: 16'h8000,
                         b_re: 16'h0000, b_im: 16'h0000});
    directed.push_back('{func: FUNC_DIV, a_re: 16'h7fff, a_im: 16'h7fff,
                         b_re: 16'h0001, b_im: 16'h0000});
    directed.push_back('{func: FUNC_DIV, a_re: 16'hffff, a_im: 16'h0001,
                         b_re: 16'h7fff, b_im: 16'h7fff});
    foreach (directed[i]) send(directed[i]);
    for (n = 0; n < 1750; n++) begin
      calm = (n >= 600 && n < 900);
      o = random_op();
      send(o);
    end
    op_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("complex_arithmetic_unit: match");
    else $display("complex_arithmetic_unit: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("complex_arithmetic_unit: mismatch");
    $finish;
  end
endmodule
